// ===== design/ehw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 extension header walker package
// Shared widths, next-header codes, status codes, item, state and result types.
// ----------------------------------------------------------------------------
package ehw_pkg;

  // Width of the running byte offset; the chain may not run past its top value.
  localparam int OFFSET_WIDTH     = 16;
  // Fixed width of the reported payload offset field.
  localparam int PAYLOAD_OFFSET_W = 16;

  // Next-header codes.
  localparam logic [7:0] NH_HOP_BY_HOP = 8'h00;
  localparam logic [7:0] NH_ROUTING    = 8'h2B;
  localparam logic [7:0] NH_FRAGMENT   = 8'h2C;
  localparam logic [7:0] NH_NO_NEXT    = 8'h3B;
  localparam logic [7:0] NH_DEST_OPTS  = 8'h3C;
  localparam logic [7:0] NH_MOBILITY   = 8'h87;

  // Fragment header length in bytes.
  localparam logic [11:0] FRAG_HDR_LEN = 12'd8;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_OVERFLOW   = 2'd1;
  localparam logic [1:0] ST_NO_PAYLOAD = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_packet;
    logic [7:0] initial_next_header;
    logic       end_of_buffer;
  } ehw_item_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic [7:0]                  upper_protocol;
    logic [PAYLOAD_OFFSET_W-1:0] payload_offset;
  } ehw_result_t;

  typedef struct packed {
    logic                    finished;
    logic [7:0]              cur_nh;
    logic [7:0]              pend_nh;
    logic [10:0]             byte_in_hdr;
    logic [11:0]             hdr_len;
    logic                    is_frag;
    logic [7:0]              frag_hi;
    logic [OFFSET_WIDTH-1:0] byte_offset;
  } ehw_state_t;

  // True for every header the walker skips over.
  function automatic logic is_ext(input logic [7:0] nh);
    return (nh == NH_HOP_BY_HOP) || (nh == NH_ROUTING) || (nh == NH_DEST_OPTS) ||
           (nh == NH_MOBILITY) || (nh == NH_FRAGMENT);
  endfunction

endpackage

// ===== design/ehw_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Walker input channel
// Valid/ready channel carrying one packet byte and its framing flags.
// ----------------------------------------------------------------------------
interface ehw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_packet;
  logic [7:0] initial_next_header;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output start_of_packet,
                  output initial_next_header, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input start_of_packet,
                  input initial_next_header, input end_of_buffer, output ready);
endinterface

// ===== design/ehw_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Walker result channel
// Valid/ready channel carrying one chain result per packet.
// ----------------------------------------------------------------------------
interface ehw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  upper_protocol;
  logic [15:0] payload_offset;

  modport source (output valid, output status, output upper_protocol,
                  output payload_offset, input ready);
  modport sink   (input valid, input status, input upper_protocol,
                  input payload_offset, output ready);
endinterface

// ===== design/ehw_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Walker step logic
// Combinational next-state and result logic for one packet byte.
// ----------------------------------------------------------------------------
module ehw_walk (
  input  ehw_pkg::ehw_item_t   item,
  input  ehw_pkg::ehw_state_t  state,
  output ehw_pkg::ehw_state_t  state_nxt,
  output logic                 res_valid,
  output ehw_pkg::ehw_result_t res
);
  import ehw_pkg::*;

  always_comb begin
    ehw_state_t  st;
    logic        done;
    logic [10:0] i;
    logic [8:0]  len_units;

    st        = state;
    done      = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    i         = '0;
    len_units = '0;

    // A new packet restarts the walk from the fixed header's next-header value.
    if (item.start_of_packet) begin
      st.finished    = 1'b0;
      st.cur_nh      = item.initial_next_header;
      st.pend_nh     = '0;
      st.byte_in_hdr = '0;
      st.hdr_len     = '0;
      st.is_frag     = 1'b0;
      st.frag_hi     = '0;
      st.byte_offset = '0;
      if (!is_ext(st.cur_nh)) begin
        done        = 1'b1;
        res_valid   = 1'b1;
        st.finished = 1'b1;
        if (st.cur_nh == NH_NO_NEXT) begin
          res.status = ST_NO_PAYLOAD;
        end else begin
          res.status         = ST_OK;
          res.upper_protocol = st.cur_nh;
        end
      end
    end

    if (!done && !st.finished) begin
      i = st.byte_in_hdr;

      // Pick up the header fields that sit at fixed positions.
      if (i == 11'd0) begin
        st.pend_nh = item.data_byte;
        st.is_frag = (st.cur_nh == NH_FRAGMENT);
        st.hdr_len = st.is_frag ? FRAG_HDR_LEN : 12'd0;
      end else if (i == 11'd1) begin
        if (!st.is_frag) begin
          len_units  = {1'b0, item.data_byte} + 9'd1;
          st.hdr_len = {len_units, 3'b000};
        end
      end else if (st.is_frag && i == 11'd2) begin
        st.frag_hi = item.data_byte;
      end else if (st.is_frag && i == 11'd3) begin
        // A nonzero fragment offset means a later fragment without a payload.
        if ({st.frag_hi, item.data_byte[7:3]} != 13'd0) begin
          done        = 1'b1;
          res_valid   = 1'b1;
          res.status  = ST_NO_PAYLOAD;
          st.finished = 1'b1;
        end
      end

      // The offset may not run past its top value.
      if (!done) begin
        if (&st.byte_offset) begin
          done        = 1'b1;
          res_valid   = 1'b1;
          res.status  = ST_OVERFLOW;
          st.finished = 1'b1;
        end else begin
          st.byte_offset = st.byte_offset + 1'b1;
        end
      end

      // At the last byte of a header, move on to the next one.
      if (!done) begin
        if (st.hdr_len != 12'd0 && ({1'b0, i} + 12'd1) == st.hdr_len) begin
          st.cur_nh      = st.pend_nh;
          st.byte_in_hdr = '0;
          st.hdr_len     = '0;
          st.is_frag     = 1'b0;
          if (!is_ext(st.cur_nh)) begin
            done        = 1'b1;
            res_valid   = 1'b1;
            st.finished = 1'b1;
            if (st.cur_nh == NH_NO_NEXT) begin
              res.status = ST_NO_PAYLOAD;
            end else begin
              res.status         = ST_OK;
              res.upper_protocol = st.cur_nh;
              res.payload_offset = PAYLOAD_OFFSET_W'(st.byte_offset);
            end
          end
        end else begin
          st.byte_in_hdr = i + 11'd1;
        end
      end

      // The buffer ran out with the chain still open.
      if (!done && item.end_of_buffer) begin
        res_valid   = 1'b1;
        res.status  = ST_OVERFLOW;
        st.finished = 1'b1;
      end
    end

    state_nxt = st;
  end

endmodule

// ===== design/ipv6_extension_header_walker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 extension header walker
// Walks the extension header chain after a fixed IPv6 header and reports the
// upper-layer protocol with its payload offset, no payload, or overflow.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one packet byte per transfer. start_of_packet marks the
//   first byte and qualifies initial_next_header; end_of_buffer marks the last
//   byte available. out_chan carries at most one result per packet: status,
//   upper_protocol and payload_offset (the latter two are zero unless ok).
//   A new start_of_packet drops an unfinished walk without a result; bytes
//   after a result and before the next start are ignored.
// Timing:
//   An input transfer is registered, then evaluated against the walk state
//   once the result register can take its result, and any result lands in the
//   output register. One byte is taken every cycle while the output register
//   is empty or being drained; the byte register and the result register
//   decouple the two channels.
// Reset and stall:
//   Reset empties both registers and leaves the walker waiting for a start
//   of packet. While out_chan stalls with a result held, one more byte is
//   taken into the input register and then in_chan.ready falls.
// ----------------------------------------------------------------------------
module ipv6_extension_header_walker_unit (
  input logic  clk,
  input logic  rst_n,
  ehw_in_if.sink    in_chan,
  ehw_out_if.source out_chan
);
  import ehw_pkg::*;

  logic        s1_valid_r;
  ehw_item_t   s1_item_r;
  logic        out_valid_r;
  ehw_result_t out_res_r;
  ehw_state_t  state_r;

  ehw_state_t  state_nxt;
  logic        res_valid;
  ehw_result_t res;
  logic        advance;
  logic        in_xfer;

  // The held byte is evaluated whenever the result register can take its result.
  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  // Step logic for the held byte.
  ehw_walk u_walk (
    .item      (s1_item_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
    if (in_xfer) begin
      s1_item_r.data_byte           <= in_chan.data_byte;
      s1_item_r.start_of_packet     <= in_chan.start_of_packet;
      s1_item_r.initial_next_header <= in_chan.initial_next_header;
      s1_item_r.end_of_buffer       <= in_chan.end_of_buffer;
    end
  end

  // Walk state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ehw_state_t'{finished: 1'b1, default: '0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_res_r.status;
  assign out_chan.upper_protocol = out_res_r.upper_protocol;
  assign out_chan.payload_offset = out_res_r.payload_offset;

  // A shown result never carries the unused status code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.status == ST_OK || out_res_r.status == ST_OVERFLOW ||
                     out_res_r.status == ST_NO_PAYLOAD))
    else $error("result status code out of range");

  // Failure results carry no protocol and no offset.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status != ST_OK) |->
      (out_res_r.upper_protocol == 8'd0 && out_res_r.payload_offset == '0))
    else $error("failure result with nonzero fields");

  // A held byte is not dropped while the result register stalls.
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_chan.ready) |=> s1_valid_r)
    else $error("held byte lost during output stall");

  // Every result ends the walk until the next start of packet.
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid) |=> state_r.finished)
    else $error("walk not finished after result");

endmodule

// ===== tb/sv/ehw_chain_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extension header chain checker
// Watches both walker channels. Every accepted byte drives a local model
// of the header walk. Every verdict that the model predicts is queued, and
// each result transfer is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module ehw_chain_checker (
  input  logic clk,
  input  logic rst_n,
  ehw_in_if    in_mon,
  ehw_out_if   out_mon,
  output int   mismatches,
  output int   results_owed
);
  import ehw_pkg::*;

  localparam logic [OFFSET_WIDTH:0] OFF_TOP = (OFFSET_WIDTH + 1)'((1 << OFFSET_WIDTH) - 1);

  // Local copy of the walk state.
  logic                  walk_done;
  logic [7:0]            nh_now;
  logic [7:0]            nh_next;
  logic [10:0]           hdr_pos;
  logic [11:0]           hdr_size;
  logic                  in_frag;
  logic [7:0]            frag_top;
  logic [OFFSET_WIDTH:0] chain_off;

  ehw_result_t pending_verdicts[$];
  int          err_cnt;

  // Headers that the walk steps over.
  function automatic bit skippable(input logic [7:0] nh);
    case (nh) inside
      NH_HOP_BY_HOP, NH_ROUTING, NH_DEST_OPTS, NH_MOBILITY, NH_FRAGMENT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Closes the walk with the given verdict.
  function automatic bit close_walk(output ehw_result_t r, input logic [1:0] st,
                                    input logic [7:0] proto,
                                    input logic [PAYLOAD_OFFSET_W-1:0] off);
    r.status         = st;
    r.upper_protocol = proto;
    r.payload_offset = off;
    walk_done        = 1'b1;
    return 1'b1;
  endfunction

  // Decides on the current next-header value; returns 1 on a verdict.
  function automatic bit decide_next(output ehw_result_t r);
    r = '0;
    if (skippable(nh_now)) return 1'b0;
    if (nh_now == NH_NO_NEXT) return close_walk(r, ST_NO_PAYLOAD, 8'd0, '0);
    return close_walk(r, ST_OK, nh_now, PAYLOAD_OFFSET_W'(chain_off));
  endfunction

  // Advances the walk by one byte; returns 1 when the byte yields a verdict.
  function automatic bit walk_byte(input ehw_item_t it, output ehw_result_t r);
    logic [10:0] pos;
    r = '0;
    if (it.start_of_packet) begin
      walk_done = 1'b0;
      nh_now    = it.initial_next_header;
      nh_next   = 8'd0;
      hdr_pos   = '0;
      hdr_size  = '0;
      in_frag   = 1'b0;
      frag_top  = 8'd0;
      chain_off = '0;
      if (decide_next(r)) return 1'b1;
    end
    if (walk_done) return 1'b0;

    pos = hdr_pos;
    if (pos == 11'd0) begin
      nh_next  = it.data_byte;
      in_frag  = (nh_now == NH_FRAGMENT);
      hdr_size = in_frag ? FRAG_HDR_LEN : 12'd0;
    end else if (pos == 11'd1) begin
      if (!in_frag) hdr_size = (12'(it.data_byte) + 12'd1) << 3;
    end else if (in_frag && pos == 11'd2) begin
      frag_top = it.data_byte;
    end else if (in_frag && pos == 11'd3) begin
      // A nonzero fragment offset means this is not the first fragment.
      if ({frag_top, it.data_byte[7:3]} != 13'd0)
        return close_walk(r, ST_NO_PAYLOAD, 8'd0, '0);
    end

    if (chain_off >= OFF_TOP) return close_walk(r, ST_OVERFLOW, 8'd0, '0);
    chain_off = chain_off + 1'b1;

    if (hdr_size != 12'd0 && 12'(pos) + 12'd1 == hdr_size) begin
      nh_now   = nh_next;
      hdr_pos  = '0;
      hdr_size = '0;
      in_frag  = 1'b0;
      if (decide_next(r)) return 1'b1;
    end else begin
      hdr_pos = pos + 11'd1;
    end

    if (it.end_of_buffer) return close_walk(r, ST_OVERFLOW, 8'd0, '0);
    return 1'b0;
  endfunction

  function automatic void count_error();
    err_cnt++;
  endfunction

  // Result transfers are checked before the byte of the same edge is modeled.
  always @(posedge clk) begin
    ehw_item_t   it;
    ehw_result_t want;
    ehw_result_t got;
    if (!rst_n) begin
      walk_done = 1'b1;
      nh_now    = 8'd0;
      nh_next   = 8'd0;
      hdr_pos   = '0;
      hdr_size  = '0;
      in_frag   = 1'b0;
      frag_top  = 8'd0;
      chain_off = '0;
      err_cnt   = 0;
      pending_verdicts.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.status         = out_mon.status;
        got.upper_protocol = out_mon.upper_protocol;
        got.payload_offset = out_mon.payload_offset;
        if (pending_verdicts.size() == 0) begin
          count_error();
          if (err_cnt <= 10)
            $display("[%0t] unexpected result: status %0d proto %0d offset %0d",
                     $time, got.status, got.upper_protocol, got.payload_offset);
        end else begin
          want = pending_verdicts.pop_front();
          if (got.status != want.status || got.upper_protocol != want.upper_protocol ||
              got.payload_offset != want.payload_offset) begin
            count_error();
            if (err_cnt <= 10)
              $display("[%0t] mismatch: status %0d/%0d proto %0d/%0d offset %0d/%0d (exp/act)",
                       $time, want.status, got.status, want.upper_protocol,
                       got.upper_protocol, want.payload_offset, got.payload_offset);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        it.data_byte           = in_mon.data_byte;
        it.start_of_packet     = in_mon.start_of_packet;
        it.initial_next_header = in_mon.initial_next_header;
        it.end_of_buffer       = in_mon.end_of_buffer;
        if (walk_byte(it, want)) pending_verdicts.push_back(want);
      end
    end
    mismatches   <= err_cnt;
    results_owed <= pending_verdicts.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extension header walker testbench
// Feeds directed and random IPv6 extension header chains to the walker with
// random gaps and back-pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ehw_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_BYTES = 1760;

  logic clk;
  logic rst_n;
  bit   calm;
  int   mismatches;
  int   results_owed;
  int   fed;
  int   quiet;
  logic [7:0] pkt[$];

  ehw_in_if  in_chan();
  ehw_out_if out_chan();

  ipv6_extension_header_walker_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  ehw_chain_checker u_chain_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    if (calm) begin
      out_chan.ready <= 1'b1;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= 23);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one byte, with random gaps before it, and waits for its transfer.
  task automatic feed(input logic [7:0] b, input bit sop, input logic [7:0] inh,
                      input bit eob);
    while (!calm && $urandom_range(99) < 23) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid               <= 1'b1;
    in_chan.data_byte           <= b;
    in_chan.start_of_packet     <= sop;
    in_chan.initial_next_header <= inh;
    in_chan.end_of_buffer       <= eob;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Stops sending until every predicted verdict has been received.
  task automatic drain_verdicts();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // Options-style header: next header, length byte, then padding.
  function automatic void put_opt_hdr(input logic [7:0] nxt, input logic [7:0] len8);
    int k;
    pkt.push_back(nxt);
    pkt.push_back(len8);
    for (k = 2; k < (int'(len8) + 1) * 8; k++) pkt.push_back(8'($urandom));
  endfunction

  // Fragment header with the given 13-bit fragment offset.
  function automatic void put_frag_hdr(input logic [7:0] nxt, input logic [12:0] foff);
    int k;
    pkt.push_back(nxt);
    pkt.push_back(8'($urandom));
    pkt.push_back(foff[12:5]);
    pkt.push_back({foff[4:0], 3'($urandom)});
    for (k = 0; k < 4; k++) pkt.push_back(8'($urandom));
  endfunction

  // Sends the built bytes as one packet and empties the buffer.
  task automatic send_packet(input logic [7:0] first_nh, input bit eob_last);
    int n;
    int k;
    if (pkt.size() == 0) pkt.push_back(8'($urandom));
    n = pkt.size();
    for (k = 0; k < n; k++)
      feed(pkt[k], k == 0, (k == 0) ? first_nh : 8'($urandom), eob_last && k == n - 1);
    pkt.delete();
  endtask

  // Random chain of up to four headers, sometimes truncated, plus payload.
  task automatic random_packet();
    logic [7:0] kinds[$];
    logic [7:0] last_nh;
    logic [7:0] first_nh;
    logic [7:0] nxt;
    int hops;
    int roll;
    int k;
    int cut;
    bit eob;
    hops = $urandom_range(4);
    for (k = 0; k < hops; k++) begin
      case ($urandom_range(4))
        0: kinds.push_back(NH_HOP_BY_HOP);
        1: kinds.push_back(NH_ROUTING);
        2: kinds.push_back(NH_DEST_OPTS);
        3: kinds.push_back(NH_MOBILITY);
        default: kinds.push_back(NH_FRAGMENT);
      endcase
    end
    last_nh = ($urandom_range(9) == 0) ? NH_NO_NEXT : 8'($urandom);
    for (k = 0; k < hops; k++) begin
      nxt = (k + 1 < hops) ? kinds[k + 1] : last_nh;
      if (kinds[k] == NH_FRAGMENT) begin
        put_frag_hdr(nxt, $urandom_range(1) ? 13'd0 : 13'($urandom));
      end else begin
        put_opt_hdr(nxt, ($urandom_range(9) == 0) ? 8'($urandom_range(31))
                                                  : 8'($urandom_range(3)));
      end
    end
    first_nh = (hops != 0) ? kinds[0] : last_nh;
    fed += pkt.size() + 1;

    roll = $urandom_range(99);
    if (roll < 15 && pkt.size() > 1) begin
      // Broken chain: cut short, usually flagged as the buffer end.
      cut = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > cut) void'(pkt.pop_back());
      eob = ($urandom_range(2) != 0);
    end else begin
      for (k = $urandom_range(6); k > 0; k--) pkt.push_back(8'($urandom));
      eob = ($urandom_range(99) < 80);
    end
    send_packet(first_nh, eob);

    // Stray bytes between packets.
    if ($urandom_range(19) == 0) begin
      for (k = $urandom_range(1, 3); k > 0; k--)
        feed(8'($urandom), 1'b0, 8'($urandom), 1'(($urandom)));
    end
  endtask

  initial begin
    int next_drain;
    rst_n                       = 1'b0;
    calm                        = 1'b0;
    fed                         = 0;
    in_chan.valid               = 1'b0;
    in_chan.data_byte           = 8'd0;
    in_chan.start_of_packet     = 1'b0;
    in_chan.initial_next_header = 8'd0;
    in_chan.end_of_buffer       = 1'b0;
    out_chan.ready              = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Upper-layer protocol straight from the fixed header.
    pkt.push_back(8'hFF);
    send_packet(8'hFF, 1'b1);
    // No next header straight from the fixed header.
    pkt.push_back(8'h00);
    send_packet(NH_NO_NEXT, 1'b0);
    // Every extension type in one chain, buffer end on the resolving byte.
    put_opt_hdr(NH_FRAGMENT, 8'd0);
    put_frag_hdr(NH_DEST_OPTS, 13'd0);
    put_opt_hdr(NH_MOBILITY, 8'd1);
    put_opt_hdr(NH_HOP_BY_HOP, 8'd0);
    put_opt_hdr(8'd6, 8'd0);
    send_packet(NH_ROUTING, 1'b1);
    // Non-first fragments: largest and smallest nonzero fragment offset.
    put_frag_hdr(8'd17, 13'h1FFF);
    send_packet(NH_FRAGMENT, 1'b0);
    put_frag_hdr(8'd17, 13'd1);
    send_packet(NH_FRAGMENT, 1'b1);
    // First fragment with all flag bits set, followed by no next header.
    put_frag_hdr(NH_NO_NEXT, 13'd0);
    pkt[3] = 8'h07;
    send_packet(NH_FRAGMENT, 1'b1);
    // Buffer ends on the first byte of a chain.
    pkt.push_back(8'h00);
    send_packet(NH_HOP_BY_HOP, 1'b1);
    // Unfinished walk dropped by a new start of packet.
    put_opt_hdr(8'd6, 8'd0);
    while (pkt.size() > 3) void'(pkt.pop_back());
    send_packet(NH_ROUTING, 1'b0);
    put_opt_hdr(8'd58, 8'd0);
    send_packet(NH_HOP_BY_HOP, 1'b1);
    // Bytes after a verdict are ignored.
    feed(8'h00, 1'b0, 8'hFF, 1'b1);
    feed(8'hFF, 1'b0, 8'h00, 1'b0);
    drain_verdicts();

    // Random chains, with a stretch free of gaps and periodic full drains.
    next_drain = 450;
    while (fed < RANDOM_BYTES) begin
      calm <= (fed >= 700 && fed < 1100);
      random_packet();
      if (fed >= next_drain) begin
        drain_verdicts();
        next_drain += 450;
      end
    end

    drain_verdicts();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
